@@ hdl/tlshs_pkg.sv @@
// Shared types and constants for the TLS handshake message checker.
// No dependencies. Used by the checker top level and its assertion checker.
`timescale 1ns / 1ps
`default_nettype none

package tlshs_pkg;

  // Expected message kinds, as carried on the action field
  localparam logic [2:0] KIND_CLIENT_HELLO = 3'd0;
  localparam logic [2:0] KIND_SERVER_HELLO = 3'd1;
  localparam logic [2:0] KIND_HELLO_DONE   = 3'd2;
  localparam logic [2:0] KIND_KEY_EXCHANGE = 3'd3;
  localparam logic [2:0] KIND_CHANGE_SPEC  = 3'd4;

  // Handshake type bytes and fixed field values
  localparam logic [7:0] HS_CLIENT_HELLO = 8'd1;
  localparam logic [7:0] HS_SERVER_HELLO = 8'd2;
  localparam logic [7:0] HS_HELLO_DONE   = 8'd14;
  localparam logic [7:0] HS_KEY_EXCHANGE = 8'd16;
  localparam logic [7:0] VERSION_BYTE    = 8'd3;
  localparam logic [7:0] CCS_BYTE        = 8'd1;
  localparam logic [7:0] NULL_COMP       = 8'd0;

  // Byte positions in the hello fixed part
  localparam logic [15:0] POS_TYPE       = 16'd0;
  localparam logic [15:0] POS_LEN_TOP    = 16'd1;
  localparam logic [15:0] POS_LEN_HI     = 16'd2;
  localparam logic [15:0] POS_LEN_LO     = 16'd3;
  localparam logic [15:0] POS_VER_MAJOR  = 16'd4;
  localparam logic [15:0] POS_VER_MINOR  = 16'd5;
  localparam logic [15:0] POS_SID_LEN    = 16'd38;

  localparam logic [16:0] HDR_BYTES      = 17'd4;
  localparam logic [16:0] HDR_KX_BYTES   = 17'd6;
  localparam logic [15:0] HELLO_DONE_LEN = 16'd4;

  localparam logic [15:0] SUITE_RESET    = 16'hC0A8;

  typedef enum logic [2:0] {
    V_OK         = 3'd0,
    V_UNEXPECTED = 3'd1,
    V_ILLEGAL    = 3'd2,
    V_HS_FAIL    = 3'd3,
    V_DECODE     = 3'd4
  } verdict_e;

  typedef enum logic [13:0] {
    PH_IDLE     = 14'b00000000000001,
    PH_FIXED    = 14'b00000000000010,
    PH_SID      = 14'b00000000000100,
    PH_SUITE_HI = 14'b00000000001000,
    PH_SUITE_LO = 14'b00000000010000,
    PH_COMP     = 14'b00000000100000,
    PH_CLEN_HI  = 14'b00000001000000,
    PH_CLEN_LO  = 14'b00000010000000,
    PH_CSCAN_HI = 14'b00000100000000,
    PH_CSCAN_LO = 14'b00001000000000,
    PH_CSKIP    = 14'b00010000000000,
    PH_MLEN     = 14'b00100000000000,
    PH_MSCAN    = 14'b01000000000000,
    PH_DONE     = 14'b10000000000000
  } phase_e;

endpackage

`default_nettype wire

@@ hdl/tls_handshake_message_checker.sv @@
// TLS 1.2 handshake message checker, one message byte per word.
// Depends on tlshs_pkg.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+----------------------------------------
//  in       | sink      | in_valid_i / in_stall_o | action, message_length, data_byte,
//           |           |                         | first_byte, last_byte
//  out      | source    | out_valid_o / out_stall_i | verdict, checked_kind
//  cfg      | sink      | cfg_wen_i (no wait)     | cfg_wdata_i -> required suite
//
// One word per clock while in_stall_o is low. Each byte is parsed by a single layer of
// compares and counter updates between the parser state registers and the result
// register, so the result for a last byte appears on the cycle after it is taken.
// in_stall_o only rises while a finished result sits in the output register and the
// far side stalls it; bytes that give no result still pass if the output is free.
// Reset (rst_ni low, asynchronous) leaves the parser idle, the output empty and the
// required suite at 0xC0A8.
`timescale 1ns / 1ps
`default_nettype none

module tls_handshake_message_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // byte stream
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  action_i,
  input  wire logic [15:0] message_length_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        first_byte_i,
  input  wire logic        last_byte_i,
  // verdicts
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       verdict_o,
  output logic [2:0]       checked_kind_o,
  // required suite register
  input  wire logic        cfg_wen_i,
  input  wire logic [15:0] cfg_wdata_i
);
  import tlshs_pkg::*;

  // parser state
  phase_e      phase_q, phase_d;
  logic [15:0] pos_q, pos_d;        // byte position, saturating
  logic [15:0] cnt_q, cnt_d;        // field countdown
  logic [7:0]  hold_q, hold_d;      // high byte of a 16-bit field
  verdict_e    fail_q, fail_d;      // first failure seen
  logic [2:0]  kind_q, kind_d;
  logic [15:0] mlen_q, mlen_d;
  logic [15:0] suite_q;

  // result register
  logic        res_valid_q, res_valid_d;
  logic [2:0]  res_verdict_q;
  logic [2:0]  res_kind_q;

  logic        in_fire;
  logic        res_fire;
  verdict_e    res_verdict;

  // view of the current word: a type byte restarts everything
  logic [2:0]  kind_w;
  logic [15:0] ml_w;
  logic [15:0] pos_w;
  logic [15:0] pair_w;
  logic        hdr_mismatch;
  logic        clen_bad;
  logic        mlen_bad;
  logic [15:0] cnt_m1;
  logic [15:0] cnt_m2;

  assign in_stall_o = res_valid_q & out_stall_i;
  assign in_fire    = in_valid_i & ~in_stall_o;

  assign kind_w = first_byte_i ? action_i : kind_q;
  assign ml_w   = first_byte_i ? message_length_i : mlen_q;
  assign pos_w  = first_byte_i ? 16'd0 :
                  (pos_q == 16'hFFFF) ? pos_q : pos_q + 16'd1;
  assign pair_w = {hold_q, data_byte_i};
  assign cnt_m1 = cnt_q - 16'd1;
  assign cnt_m2 = cnt_q - 16'd2;

  // header length field: value plus header size must hit the message length exactly
  assign hdr_mismatch = ({1'b0, pair_w} +
                         ((pos_w == 16'd5) ? HDR_KX_BYTES : HDR_BYTES)) != {1'b0, ml_w};
  // inner length fields must fit in what is left of the message
  assign clen_bad = ({2'b0, pair_w} + {2'b0, pos_w} + 18'd1) > {2'b0, ml_w};
  assign mlen_bad = ({10'b0, data_byte_i} + {2'b0, pos_w} + 18'd1) > {2'b0, ml_w};

  always_comb begin
    phase_e   cur;
    logic     run;
    logic     open;
    logic     fail_en;
    verdict_e fail_v;

    cur     = phase_q;
    run     = 1'b0;
    open    = 1'b0;
    fail_en = 1'b0;
    fail_v  = V_OK;

    phase_d  = phase_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    hold_d   = hold_q;
    fail_d   = fail_q;
    kind_d   = kind_q;
    mlen_d   = mlen_q;
    res_fire = 1'b0;

    if (in_fire) begin
      if (first_byte_i) begin
        kind_d = action_i;
        mlen_d = message_length_i;
        pos_d  = 16'd0;
        cnt_d  = 16'd0;
        hold_d = 8'd0;
        fail_d = V_OK;
        cur    = PH_FIXED;
        run    = 1'b1;
        open   = 1'b1;
      end else if (phase_q != PH_IDLE) begin
        pos_d = pos_w;
        run   = (phase_q != PH_DONE);
        open  = 1'b1;
      end
    end
    phase_d = cur;

    if (run) begin
      unique case (cur)
        PH_FIXED: begin
          case (kind_w) inside
            KIND_CLIENT_HELLO, KIND_SERVER_HELLO: begin
              if (pos_w == POS_TYPE) begin
                if (data_byte_i != ((kind_w == KIND_CLIENT_HELLO) ?
                                    HS_CLIENT_HELLO : HS_SERVER_HELLO)) begin
                  fail_en = 1'b1; fail_v = V_UNEXPECTED;
                end
              end else if (pos_w == POS_LEN_TOP) begin
                if (data_byte_i != 8'd0) begin
                  fail_en = 1'b1; fail_v = V_DECODE;
                end
              end else if (pos_w == POS_LEN_HI) begin
                hold_d = data_byte_i;
              end else if (pos_w == POS_LEN_LO) begin
                if (hdr_mismatch) begin
                  fail_en = 1'b1; fail_v = V_DECODE;
                end
              end else if (pos_w == POS_VER_MAJOR || pos_w == POS_VER_MINOR) begin
                if (data_byte_i != VERSION_BYTE) begin
                  fail_en = 1'b1; fail_v = V_ILLEGAL;
                end
              end else if (pos_w == POS_SID_LEN) begin
                cnt_d = {8'd0, data_byte_i};
                if (data_byte_i != 8'd0) phase_d = PH_SID;
                else if (kind_w == KIND_CLIENT_HELLO) phase_d = PH_CLEN_HI;
                else phase_d = PH_SUITE_HI;
              end
            end
            KIND_HELLO_DONE: begin
              if (pos_w == POS_TYPE) begin
                if (data_byte_i != HS_HELLO_DONE) begin
                  fail_en = 1'b1; fail_v = V_UNEXPECTED;
                end else if (ml_w != HELLO_DONE_LEN) begin
                  fail_en = 1'b1; fail_v = V_DECODE;
                end
              end else if (pos_w <= POS_LEN_LO) begin
                if (data_byte_i != 8'd0) begin
                  fail_en = 1'b1; fail_v = V_DECODE;
                end else if (pos_w == POS_LEN_LO) begin
                  phase_d = PH_DONE;
                end
              end
            end
            KIND_KEY_EXCHANGE: begin
              if (pos_w == POS_TYPE) begin
                if (data_byte_i != HS_KEY_EXCHANGE) begin
                  fail_en = 1'b1; fail_v = V_UNEXPECTED;
                end
              end else if (pos_w == POS_LEN_TOP) begin
                if (data_byte_i != 8'd0) begin
                  fail_en = 1'b1; fail_v = V_DECODE;
                end
              end else if (pos_w == POS_LEN_HI || pos_w == POS_VER_MAJOR) begin
                hold_d = data_byte_i;
              end else if (pos_w == POS_LEN_LO || pos_w == POS_VER_MINOR) begin
                // second length field sits at 4..5, so header and field make six bytes before the body
                if (hdr_mismatch) begin
                  fail_en = 1'b1; fail_v = V_DECODE;
                end else if (pos_w == POS_VER_MINOR) begin
                  phase_d = PH_DONE;
                end
              end
            end
            KIND_CHANGE_SPEC: begin
              if (data_byte_i != CCS_BYTE) begin
                fail_en = 1'b1; fail_v = V_DECODE;
              end else begin
                phase_d = PH_DONE;
              end
            end
            default: phase_d = PH_DONE;  // finished and spare codes pass
          endcase
        end
        PH_SID: begin
          cnt_d = cnt_m1;
          if (cnt_m1 == 16'd0) begin
            phase_d = (kind_w == KIND_CLIENT_HELLO) ? PH_CLEN_HI : PH_SUITE_HI;
          end
        end
        PH_SUITE_HI: begin
          if (data_byte_i != suite_q[15:8]) begin
            fail_en = 1'b1; fail_v = V_HS_FAIL;
          end else phase_d = PH_SUITE_LO;
        end
        PH_SUITE_LO: begin
          if (data_byte_i != suite_q[7:0]) begin
            fail_en = 1'b1; fail_v = V_HS_FAIL;
          end else phase_d = PH_COMP;
        end
        PH_COMP: begin
          if (data_byte_i != NULL_COMP) begin
            fail_en = 1'b1; fail_v = V_HS_FAIL;
          end else phase_d = PH_DONE;
        end
        PH_CLEN_HI: begin
          hold_d  = data_byte_i;
          phase_d = PH_CLEN_LO;
        end
        PH_CLEN_LO: begin
          if (clen_bad || pair_w[0]) begin
            fail_en = 1'b1; fail_v = V_DECODE;
          end else if (pair_w == 16'd0) begin
            fail_en = 1'b1; fail_v = V_HS_FAIL;
          end else begin
            cnt_d   = pair_w;
            phase_d = PH_CSCAN_HI;
          end
        end
        PH_CSCAN_HI: begin
          hold_d  = data_byte_i;
          phase_d = PH_CSCAN_LO;
        end
        PH_CSCAN_LO: begin
          cnt_d = cnt_m2;
          if (pair_w == suite_q) begin
            phase_d = (cnt_m2 == 16'd0) ? PH_MLEN : PH_CSKIP;
          end else if (cnt_m2 == 16'd0) begin
            fail_en = 1'b1; fail_v = V_HS_FAIL;
          end else begin
            phase_d = PH_CSCAN_HI;
          end
        end
        PH_CSKIP: begin
          cnt_d = cnt_m1;
          if (cnt_m1 == 16'd0) phase_d = PH_MLEN;
        end
        PH_MLEN: begin
          if (mlen_bad) begin
            fail_en = 1'b1; fail_v = V_DECODE;
          end else if (data_byte_i == 8'd0) begin
            fail_en = 1'b1; fail_v = V_HS_FAIL;
          end else begin
            cnt_d   = {8'd0, data_byte_i};
            phase_d = PH_MSCAN;
          end
        end
        PH_MSCAN: begin
          cnt_d = cnt_m1;
          if (data_byte_i == NULL_COMP) phase_d = PH_DONE;
          else if (cnt_m1 == 16'd0) begin
            fail_en = 1'b1; fail_v = V_HS_FAIL;
          end
        end
        default: ;
      endcase
    end

    if (fail_en) begin
      fail_d  = fail_v;
      phase_d = PH_DONE;
    end

    res_verdict = V_OK;
    if (fail_d != V_OK) res_verdict = fail_d;
    else if (phase_d != PH_DONE) res_verdict = V_DECODE;

    if (open && last_byte_i) begin
      res_fire = 1'b1;
      phase_d  = PH_IDLE;
    end
  end

  // output register: holds while stalled, empties when taken
  always_comb begin
    res_valid_d = res_valid_q & out_stall_i;
    if (res_fire) res_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      pos_q       <= 16'd0;
      cnt_q       <= 16'd0;
      hold_q      <= 8'd0;
      fail_q      <= V_OK;
      kind_q      <= 3'd0;
      mlen_q      <= 16'd0;
      suite_q     <= SUITE_RESET;
      res_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      hold_q      <= hold_d;
      fail_q      <= fail_d;
      kind_q      <= kind_d;
      mlen_q      <= mlen_d;
      res_valid_q <= res_valid_d;
      if (cfg_wen_i) suite_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      res_verdict_q <= res_verdict;
      res_kind_q    <= kind_d;
    end
  end

  assign out_valid_o    = res_valid_q;
  assign verdict_o      = res_verdict_q;
  assign checked_kind_o = res_kind_q;

endmodule

`default_nettype wire

@@ hdl/tlshs_checker.sv @@
// Port-level assertions for the TLS handshake message checker, bound to the top level.
// Depends on tlshs_pkg and tls_handshake_message_checker.
`timescale 1ns / 1ps
`default_nettype none

module tlshs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [2:0]  action_i,
  input wire logic        first_byte_i,
  input wire logic        last_byte_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [2:0]  verdict_o,
  input wire logic [2:0]  checked_kind_o
);
  import tlshs_pkg::*;

  // stalled verdict word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(verdict_o) &&
                                      $stable(checked_kind_o)))
    else $error("verdict word changed while stalled");

  // a fresh verdict only follows a taken last byte
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && last_byte_i))
    else $error("verdict without a last byte");

  // a one-byte message reports at once, against the kind given with it
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && first_byte_i && last_byte_i) |=>
      (out_valid_o && checked_kind_o == $past(action_i)))
    else $error("one-byte message lost or wrong kind");

  // a one-byte client hello can never pass
  a_short_hello: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && first_byte_i && last_byte_i &&
     action_i == KIND_CLIENT_HELLO) |=> (verdict_o != V_OK))
    else $error("truncated client hello passed");

  // verdict codes stay in range
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (verdict_o <= V_DECODE))
    else $error("verdict code out of range");

endmodule

bind tls_handshake_message_checker tlshs_checker u_tlshs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .action_i       (action_i),
  .first_byte_i   (first_byte_i),
  .last_byte_i    (last_byte_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .verdict_o      (verdict_o),
  .checked_kind_o (checked_kind_o)
);

`default_nettype wire
